/* design/oaht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg - shared types and constants of the open addressing hash table
// Operation and status codes, slot marks, widths and the structs passed
// between the front queue, the divider and the probe engine.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int CNT_W     = 11;
	localparam int HASH_W    = 30;
	localparam int HASH_IN_W = 32;
	localparam int KEY_W     = 64;
	localparam int VAL_W     = 64;
	localparam int MODE_W    = 2;
	localparam int STAT_W    = 3;
	localparam int S_DATA_W  = 176;
	localparam int M_DATA_W  = 168;

	localparam logic [CNT_W-1:0] BUCKET_RST = 11'd1021;

	// operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_FETCH  = 2'd3
	} mode_t;

	// slot marks
	typedef enum logic [1:0] {
		MARK_FREE    = 2'd0,
		MARK_USED    = 2'd1,
		MARK_DELETED = 2'd2
	} mark_t;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
	localparam logic [STAT_W-1:0] STAT_DUP       = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_END       = 3'd4;

	typedef struct packed {
		mode_t             mode;
		logic [HASH_W-1:0] hash;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [CNT_W-1:0]  start;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  found_key;
		logic [VAL_W-1:0]  found_value;
		logic [CNT_W-1:0]  next_index;
		logic [CNT_W-1:0]  occupied_count;
		logic [CNT_W-1:0]  tombstone_count;
	} result_t;

endpackage

/* design/oaht_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_front - input side of the hash table
// Unpacks and classifies incoming transactions and holds them in a
// two-entry queue so a busy probe engine stalls the sender only when it is full.
// ----------------------------------------------------------------------------
module oaht_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [oaht_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  logic [oaht_pkg::MODE_W-1:0]   s_axis_tuser,
	output logic                          q_valid,
	input  logic                          q_ready,
	output oaht_pkg::item_t               q_item
);

	oaht_pkg::item_t ent_q [2];
	oaht_pkg::item_t in_item;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;

	// unpack and classify, hash masked to its used bits
	always_comb begin
		in_item.mode  = oaht_pkg::mode_t'(s_axis_tuser);
		in_item.hash  = s_axis_tdata[29:0];
		in_item.key   = s_axis_tdata[95:32];
		in_item.value = s_axis_tdata[159:96];
		in_item.start = s_axis_tdata[170:160];
	end

	assign s_axis_tready = (cnt_q != 2'd2);
	assign q_valid       = (cnt_q != 2'd0);
	assign q_item        = ent_q[rd_ptr_q];
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_valid && q_ready;

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= in_item;
	end

endmodule

/* design/oaht_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_div - serial remainder unit
// Restoring division of the masked hash by the slot count, one quotient
// bit per cycle; only the remainder (home slot) is kept.
// ----------------------------------------------------------------------------
module oaht_div (
	input  logic               clk,
	input  logic               arst_n,
	input  oaht_pkg::div_req_t req,
	output oaht_pkg::div_rsp_t rsp
);

	localparam int CW = $clog2(oaht_pkg::HASH_W);
	localparam logic [CW-1:0] LAST = CW'(oaht_pkg::HASH_W - 1);

	logic [oaht_pkg::CNT_W-1:0]  rem_q;
	logic [oaht_pkg::CNT_W-1:0]  dvs_q;
	logic [oaht_pkg::HASH_W-1:0] dvd_q;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [oaht_pkg::CNT_W:0]    trial;
	logic [oaht_pkg::CNT_W-1:0]  rem_nx;

	// one restoring step
	always_comb begin
		trial = {rem_q, dvd_q[oaht_pkg::HASH_W-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_nx = oaht_pkg::CNT_W'(trial - {1'b0, dvs_q});
		end else begin
			rem_nx = trial[oaht_pkg::CNT_W-1:0];
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			dvd_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[oaht_pkg::HASH_W-2:0], 1'b0};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

/* design/oaht_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_engine - probe engine of the hash table
// Holds the slot memories, walks the linear probe slot by slot (read, then check),
// commits inserts and removes, keeps the counters and the output register.
// ----------------------------------------------------------------------------
module oaht_engine #(
	parameter int SLOT_DEPTH = oaht_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [oaht_pkg::CNT_W-1:0]  bucket,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  oaht_pkg::item_t             q_item,
	output oaht_pkg::div_req_t          div_req,
	input  oaht_pkg::div_rsp_t          div_rsp,
	output logic                        m_valid,
	input  logic                        m_ready,
	output oaht_pkg::result_t           m_res
);

	localparam int AW = $clog2(SLOT_DEPTH);
	localparam int CW = oaht_pkg::CNT_W;
	localparam logic [AW-1:0] CLR_LAST = AW'(SLOT_DEPTH - 1);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_DIV   = 7'b0000100,
		S_RD    = 7'b0001000,
		S_CHK   = 7'b0010000,
		S_WRITE = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	// slot memories
	logic [1:0]                  mark_mem [SLOT_DEPTH];
	logic [oaht_pkg::HASH_W-1:0] hash_mem [SLOT_DEPTH];
	logic [oaht_pkg::KEY_W-1:0]  key_mem  [SLOT_DEPTH];
	logic [oaht_pkg::VAL_W-1:0]  val_mem  [SLOT_DEPTH];

	state_t                      state_q;
	logic [AW-1:0]               clr_q;
	oaht_pkg::item_t             item_q;
	logic [CW-1:0]               n_q;
	logic [CW-1:0]               home_q;
	logic [CW-1:0]               idx_q;
	logic                        down_q;
	logic [CW-1:0]               pos_q;
	logic                        pos_ok_q;
	logic                        pos_free_q;
	logic [oaht_pkg::STAT_W-1:0] status_q;
	logic [oaht_pkg::KEY_W-1:0]  fkey_q;
	logic [oaht_pkg::VAL_W-1:0]  fval_q;
	logic [CW-1:0]               next_q;
	logic [CW-1:0]               used_q;
	logic [CW-1:0]               del_q;
	logic                        m_valid_q;
	oaht_pkg::result_t           res_q;

	logic [1:0]                  rd_mark_q;
	logic [oaht_pkg::HASH_W-1:0] rd_hash_q;
	logic [oaht_pkg::KEY_W-1:0]  rd_key_q;
	logic [oaht_pkg::VAL_W-1:0]  rd_val_q;

	logic [CW-1:0]               n_now;
	logic                        pop;
	logic [AW-1:0]               rd_addr;
	logic                        mem_we;
	logic                        data_we;
	logic [AW-1:0]               mem_wa;
	logic [1:0]                  mem_wmark;
	logic                        is_ins;
	logic                        match;
	logic                        out_load;
	logic [CW-1:0]               idx_inc;

	// active slot count, capped at the memory depth
	assign n_now = (32'(bucket) > 32'(SLOT_DEPTH)) ? CW'(SLOT_DEPTH) : bucket;

	assign q_ready  = (state_q == S_IDLE);
	assign pop      = q_valid && q_ready;
	assign is_ins   = (item_q.mode == oaht_pkg::MODE_INSERT);
	assign idx_inc  = idx_q + CW'(1);
	assign match    = (rd_mark_q == oaht_pkg::MARK_USED) && (rd_hash_q == item_q.hash)
		&& (rd_key_q == item_q.key);
	assign out_load = (state_q == S_DONE) && (!m_valid_q || m_ready);

	// home slot request
	assign div_req.start    = pop && (n_now != '0) && (q_item.mode != oaht_pkg::MODE_FETCH);
	assign div_req.dividend = q_item.hash;
	assign div_req.divisor  = n_now;

	// memory port control
	assign rd_addr   = AW'(idx_q);
	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
	assign data_we   = (state_q == S_WRITE) && is_ins;
	assign mem_wa    = (state_q == S_CLEAR) ? clr_q : AW'(pos_q);
	assign mem_wmark = (state_q == S_CLEAR) ? oaht_pkg::MARK_FREE :
		(is_ins ? oaht_pkg::MARK_USED : oaht_pkg::MARK_DELETED);

	// slot memories, registered reads
	always_ff @(posedge clk) begin
		if (mem_we) mark_mem[mem_wa] <= mem_wmark;
		if (data_we) begin
			hash_mem[mem_wa] <= item_q.hash;
			key_mem[mem_wa]  <= item_q.key;
			val_mem[mem_wa]  <= item_q.value;
		end
		rd_mark_q <= mark_mem[rd_addr];
		rd_hash_q <= hash_mem[rd_addr];
		rd_key_q  <= key_mem[rd_addr];
		rd_val_q  <= val_mem[rd_addr];
	end

	// operation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		logic pos_ok_n;
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			item_q     <= '0;
			n_q        <= '0;
			home_q     <= '0;
			idx_q      <= '0;
			down_q     <= 1'b0;
			pos_q      <= '0;
			pos_ok_q   <= 1'b0;
			pos_free_q <= 1'b0;
			status_q   <= oaht_pkg::STAT_OK;
			fkey_q     <= '0;
			fval_q     <= '0;
			next_q     <= '0;
			used_q     <= '0;
			del_q      <= '0;
		end else begin
			pos_ok_n = pos_ok_q;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (pop) begin
						item_q   <= q_item;
						n_q      <= n_now;
						pos_ok_q <= 1'b0;
						status_q <= oaht_pkg::STAT_OK;
						fkey_q   <= '0;
						fval_q   <= '0;
						next_q   <= '0;
						idx_q    <= q_item.start;
						down_q   <= 1'b0;
						if (q_item.mode == oaht_pkg::MODE_FETCH) begin
							if (q_item.start >= n_now) begin
								status_q <= oaht_pkg::STAT_END;
								next_q   <= n_now;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_RD;
							end
						end else if (n_now == '0) begin
							status_q <= (q_item.mode == oaht_pkg::MODE_INSERT) ?
								oaht_pkg::STAT_FULL : oaht_pkg::STAT_NOT_FOUND;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						home_q  <= div_rsp.rem;
						idx_q   <= div_rsp.rem;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (item_q.mode == oaht_pkg::MODE_FETCH) begin
						// scan upward for the next used slot
						if (rd_mark_q == oaht_pkg::MARK_USED) begin
							fkey_q  <= rd_key_q;
							fval_q  <= rd_val_q;
							next_q  <= idx_inc;
							state_q <= S_DONE;
						end else if (idx_inc == n_q) begin
							status_q <= oaht_pkg::STAT_END;
							next_q   <= n_q;
							state_q  <= S_DONE;
						end else begin
							idx_q   <= idx_inc;
							state_q <= S_RD;
						end
					end else if (rd_mark_q == oaht_pkg::MARK_FREE) begin
						// free slot ends the probe
						if (is_ins) begin
							if (!pos_ok_q) begin
								pos_q      <= idx_q;
								pos_free_q <= 1'b1;
							end
							state_q <= S_WRITE;
						end else begin
							status_q <= oaht_pkg::STAT_NOT_FOUND;
							state_q  <= S_DONE;
						end
					end else if (match) begin
						if (is_ins) begin
							status_q <= oaht_pkg::STAT_DUP;
							state_q  <= S_DONE;
						end else begin
							fval_q <= rd_val_q;
							pos_q  <= idx_q;
							state_q <= (item_q.mode == oaht_pkg::MODE_REMOVE) ? S_WRITE : S_DONE;
						end
					end else begin
						// remember the first tombstone for insert
						if (is_ins && !pos_ok_q && (rd_mark_q == oaht_pkg::MARK_DELETED)) begin
							pos_q      <= idx_q;
							pos_free_q <= 1'b0;
							pos_ok_n   = 1'b1;
						end
						pos_ok_q <= pos_ok_n;
						// advance: up to the end, then down from home-1
						if (!down_q && (idx_inc < n_q)) begin
							idx_q   <= idx_inc;
							state_q <= S_RD;
						end else if (!down_q && (home_q != '0)) begin
							idx_q   <= home_q - CW'(1);
							down_q  <= 1'b1;
							state_q <= S_RD;
						end else if (down_q && (idx_q != '0)) begin
							idx_q   <= idx_q - CW'(1);
							state_q <= S_RD;
						end else if (is_ins && pos_ok_n) begin
							state_q <= S_WRITE;
						end else begin
							status_q <= is_ins ? oaht_pkg::STAT_FULL : oaht_pkg::STAT_NOT_FOUND;
							state_q  <= S_DONE;
						end
					end
				end
				S_WRITE: begin
					// counters move on commit only
					if (!is_ins) begin
						del_q <= del_q + CW'(1);
					end else if (pos_free_q) begin
						used_q <= used_q + CW'(1);
					end else if (del_q != '0) begin
						del_q <= del_q - CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.status          <= status_q;
			res_q.found_key       <= fkey_q;
			res_q.found_value     <= fval_q;
			res_q.next_index      <= next_q;
			res_q.occupied_count  <= used_q;
			res_q.tombstone_count <= del_q;
		end
	end

	assign m_valid = m_valid_q;
	assign m_res   = res_q;

endmodule

/* design/open_addressing_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table - linear probing hash table of key/value slots
// Insert, lookup, remove and fetch-next on a table of SLOT_DEPTH slots.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction (tuser = mode, tdata =
//   hash, key, value, start index). m_axis returns exactly one result per
//   operation, in order (tuser = status, tdata = key, value, next index and
//   the two slot counters). cfg_we/cfg_wdata set the bucket count; write it
//   only while no operation is outstanding.
// Flow: an accepted operation waits in the input queue until the engine is idle;
//   insert, lookup and remove on a nonzero bucket count first get their home
//   slot from the serial modulo; then each probed slot is read and checked, a
//   committed insert or remove adds a slot write, and the result is loaded
//   into the output register. One operation is worked on at a time: the engine
//   takes a new one only from its idle state.
// Reset: the slot marks are cleared by a pass over all SLOT_DEPTH slots after
//   reset; operations queue up but are not started until it ends.
// Stall: a two-entry input queue and the output register decouple the
//   sides; a result held by a stalled receiver stalls the engine at the next result.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
	parameter int SLOT_DEPTH = oaht_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: bucket_count
	input  logic                          cfg_we,
	input  logic [oaht_pkg::CNT_W-1:0]    cfg_wdata,
	// operations
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// hash[31:0], key[95:32], value[159:96], start_index[170:160]
	input  logic [oaht_pkg::S_DATA_W-1:0] s_axis_tdata,
	// mode[1:0]
	input  logic [oaht_pkg::MODE_W-1:0]   s_axis_tuser,
	// results
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// found_key[63:0], found_value[127:64], next_index[138:128],
	// occupied_count[149:139], tombstone_count[160:150]
	output logic [oaht_pkg::M_DATA_W-1:0] m_axis_tdata,
	// status[2:0]
	output logic [oaht_pkg::STAT_W-1:0]   m_axis_tuser
);

	logic [oaht_pkg::CNT_W-1:0] bucket_q;
	logic                       q_valid;
	logic                       q_ready;
	oaht_pkg::item_t            q_item;
	oaht_pkg::div_req_t         div_req;
	oaht_pkg::div_rsp_t         div_rsp;
	oaht_pkg::result_t          res;

	// bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_q <= oaht_pkg::BUCKET_RST;
		end else if (cfg_we) begin
			bucket_q <= cfg_wdata;
		end
	end

	oaht_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item)
	);

	oaht_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	oaht_engine #(
		.SLOT_DEPTH (SLOT_DEPTH)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.bucket  (bucket_q),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_res   (res)
	);

	// pack result transaction
	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {7'd0, res.tombstone_count, res.occupied_count, res.next_index,
		res.found_value, res.found_key};

	// home slot always falls inside the table
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (div_rsp.rem < div_req.divisor))
		else $error("home slot not below bucket count");

	// a new division never starts over one in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("division restarted while busy");

	// only defined status codes leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= oaht_pkg::STAT_END))
		else $error("undefined status code");

endmodule

/* verif/open_addressing_hash_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_tb - self-checking bench of the hash table
// Drives insert, lookup, remove and fetch operations through the stream
// ports under random idling on both sides. Every result is checked, field by
// field, against a fixed row or a local model of the slot array. A directed
// pass opens the run, then random traffic over several bucket count settings.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_tb;
	import oaht_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int IDLE_LIMIT = 40000;
	localparam int DRAIN      = 60;

	// one operation as driven on the bus
	typedef struct {
		mode_t       mode;
		logic [31:0] hash;
		logic [63:0] key;
		logic [63:0] value;
		logic [10:0] start;
		bit          typed;
		result_t     res;
	} op_t;

	typedef struct {
		logic [31:0] hash;
		logic [63:0] key;
	} pair_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CNT_W-1:0]    cfg_wdata = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic [MODE_W-1:0]   s_axis_tuser = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic [STAT_W-1:0]   m_axis_tuser;

	// model of the slot array
	mark_t       slot_mark [DEPTH];
	logic [29:0] slot_hash [DEPTH];
	logic [63:0] slot_key  [DEPTH];
	logic [63:0] slot_val  [DEPTH];
	logic [10:0] bucket_cnt = BUCKET_RST;
	logic [10:0] used_cnt = '0;
	logic [10:0] dead_cnt = '0;

	result_t     pending_results[$];
	pair_t       key_pool[$];
	int          fail_cnt = 0;
	int          idle_cycles = 0;
	bit          no_idle = 1'b0;

	open_addressing_hash_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// used slot with same masked hash and key
	function automatic bit slot_hit(int i, logic [29:0] h, logic [63:0] k);
		return slot_mark[i] == MARK_USED && slot_hash[i] == h && slot_key[i] == k;
	endfunction

	// index of matching slot along the probe path, -1 when absent
	function automatic int probe_slot(logic [29:0] h, logic [63:0] k, int n);
		int home;
		home = h % n;
		for (int i = home; i < n; i++) begin
			if (slot_mark[i] == MARK_FREE) return -1;
			if (slot_hit(i, h, k)) return i;
		end
		for (int i = home - 1; i >= 0; i--) begin
			if (slot_mark[i] == MARK_FREE) return -1;
			if (slot_hit(i, h, k)) return i;
		end
		return -1;
	endfunction

	// insert into the model, returns the status
	function automatic logic [2:0] table_insert(logic [29:0] h, logic [63:0] k,
			logic [63:0] v, int n);
		int home, pos, i;
		bit stopped;
		home = h % n;
		pos = -1;
		stopped = 1'b0;
		i = home;
		while (!stopped && i < n) begin
			if (slot_mark[i] == MARK_FREE) begin
				if (pos < 0) pos = i;
				stopped = 1'b1;
			end else if (slot_mark[i] == MARK_DELETED) begin
				if (pos < 0) pos = i;
			end else if (slot_hit(i, h, k)) begin
				return STAT_DUP;
			end
			i++;
		end
		i = home - 1;
		while (!stopped && i >= 0) begin
			if (slot_mark[i] == MARK_FREE) begin
				if (pos < 0) pos = i;
				stopped = 1'b1;
			end else if (slot_mark[i] == MARK_DELETED) begin
				if (pos < 0) pos = i;
			end else if (slot_hit(i, h, k)) begin
				return STAT_DUP;
			end
			i--;
		end
		if (pos < 0) return STAT_FULL;
		if (slot_mark[pos] == MARK_FREE) used_cnt = used_cnt + 11'd1;
		else if (dead_cnt != 0) dead_cnt = dead_cnt - 11'd1;
		slot_mark[pos] = MARK_USED;
		slot_hash[pos] = h;
		slot_key[pos]  = k;
		slot_val[pos]  = v;
		return STAT_OK;
	endfunction

	// result of one operation, updating the model
	function automatic result_t table_apply(op_t op);
		result_t     r;
		logic [29:0] h;
		int          n, pos;
		r = '0;
		h = op.hash[29:0];
		n = (bucket_cnt > DEPTH) ? DEPTH : bucket_cnt;
		case (op.mode)
			MODE_INSERT: begin
				r.status = (n == 0) ? STAT_FULL : table_insert(h, op.key, op.value, n);
			end
			MODE_LOOKUP, MODE_REMOVE: begin
				pos = (n == 0) ? -1 : probe_slot(h, op.key, n);
				if (pos < 0) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					r.status = STAT_OK;
					r.found_value = slot_val[pos];
					if (op.mode == MODE_REMOVE) begin
						slot_mark[pos] = MARK_DELETED;
						slot_hash[pos] = '0;
						slot_key[pos]  = '0;
						slot_val[pos]  = '0;
						dead_cnt = dead_cnt + 11'd1;
					end
				end
			end
			default: begin
				r.status = STAT_END;
				r.next_index = 11'(n);
				for (int i = op.start; i < n; i++) begin
					if (slot_mark[i] == MARK_USED) begin
						r.status = STAT_OK;
						r.found_key = slot_key[i];
						r.found_value = slot_val[i];
						r.next_index = 11'(i + 1);
						break;
					end
				end
			end
		endcase
		r.occupied_count  = used_cnt;
		r.tombstone_count = dead_cnt;
		return r;
	endfunction

	// idle draw, with stretches of back-to-back traffic
	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 14);
	endfunction

	// send one operation and record its expected result at acceptance
	task automatic send_op(op_t op);
		int      gap;
		result_t r;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op.mode;
		s_axis_tdata  <= {5'b0, op.start, op.value, op.key, op.hash};
		do @(posedge clk); while (!s_axis_tready);
		r = table_apply(op);
		pending_results.push_back(op.typed ? op.res : r);
		if (op.mode == MODE_INSERT) begin
			key_pool.push_back('{op.hash, op.key});
			if (key_pool.size() > 48) void'(key_pool.pop_front());
		end
	endtask

	// bucket count write once the pipeline is empty
	task automatic write_buckets(logic [10:0] v);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		bucket_cnt = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic op_t random_op();
		op_t   op;
		int    pick;
		pair_t p;
		op.typed = 1'b0;
		op.res   = '0;
		op.mode  = mode_t'($urandom_range(0, 3));
		op.hash  = $urandom;
		op.key   = rand64();
		op.value = rand64();
		op.start = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 1024))
			: 11'($urandom_range(0, 40));
		pick = $urandom_range(0, 9);
		// mostly reuse known keys so lookups, removes and duplicates hit
		if (key_pool.size() > 0 && pick < 7) begin
			p = key_pool[$urandom_range(0, key_pool.size() - 1)];
			op.hash = p.hash;
			op.key  = p.key;
			if (pick == 0) op.hash[31:30] = 2'($urandom_range(0, 3));
		end
		if (op.mode != MODE_INSERT && $urandom_range(0, 2) == 0) op.mode = MODE_INSERT;
		return op;
	endfunction

	// output side: random stall per result
	initial begin
		int gap;
		forever begin
			gap = draw_gap();
			@(negedge clk);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t want, got;
		if (m_axis_tvalid && m_axis_tready) begin
			got = '0;
			got.status          = m_axis_tuser;
			got.found_key       = m_axis_tdata[63:0];
			got.found_value     = m_axis_tdata[127:64];
			got.next_index      = m_axis_tdata[138:128];
			got.occupied_count  = m_axis_tdata[149:139];
			got.tombstone_count = m_axis_tdata[160:150];
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: status %0d", got.status);
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					fail_cnt++;
				end
				if (got.found_key !== want.found_key) begin
					$error("found_key: expected %h, got %h", want.found_key, got.found_key);
					fail_cnt++;
				end
				if (got.found_value !== want.found_value) begin
					$error("found_value: expected %h, got %h", want.found_value,
						got.found_value);
					fail_cnt++;
				end
				if (got.next_index !== want.next_index) begin
					$error("next_index: expected %0d, got %0d", want.next_index,
						got.next_index);
					fail_cnt++;
				end
				if (got.occupied_count !== want.occupied_count) begin
					$error("occupied_count: expected %0d, got %0d", want.occupied_count,
						got.occupied_count);
					fail_cnt++;
				end
				if (got.tombstone_count !== want.tombstone_count) begin
					$error("tombstone_count: expected %0d, got %0d", want.tombstone_count,
						got.tombstone_count);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// directed rows then random phases
	initial begin
		op_t         dir_ops[$];
		logic [10:0] phase_buckets[9];
		int          phase_items;
		for (int i = 0; i < DEPTH; i++) begin
			slot_mark[i] = MARK_FREE;
			slot_hash[i] = '0;
			slot_key[i]  = '0;
			slot_val[i]  = '0;
		end
		// empty table at reset
		dir_ops.push_back('{MODE_LOOKUP, 32'h0, 64'h0, 64'h0, 11'd0, 1,
			'{STAT_NOT_FOUND, 64'h0, 64'h0, 11'd0, 11'd0, 11'd0}});
		dir_ops.push_back('{MODE_FETCH, 32'h0, 64'h0, 64'h0, 11'd0, 1,
			'{STAT_END, 64'h0, 64'h0, 11'd1021, 11'd0, 11'd0}});
		dir_ops.push_back('{MODE_REMOVE, '1, '1, '1, '1, 1,
			'{STAT_NOT_FOUND, 64'h0, 64'h0, 11'd0, 11'd0, 11'd0}});
		// field extremes
		dir_ops.push_back('{MODE_INSERT, 32'h0, 64'h0, 64'h0, 11'd0, 1,
			'{STAT_OK, 64'h0, 64'h0, 11'd0, 11'd1, 11'd0}});
		dir_ops.push_back('{MODE_INSERT, '1, '1, '1, '1, 1,
			'{STAT_OK, 64'h0, 64'h0, 11'd0, 11'd2, 11'd0}});
		dir_ops.push_back('{MODE_INSERT, 32'h0, 64'h0, 64'h5, 11'd0, 1,
			'{STAT_DUP, 64'h0, 64'h0, 11'd0, 11'd2, 11'd0}});
		// upper hash bits are ignored
		dir_ops.push_back('{MODE_INSERT, 32'hc000_0000, 64'h0, 64'h6, 11'd0, 1,
			'{STAT_DUP, 64'h0, 64'h0, 11'd0, 11'd2, 11'd0}});
		// collisions, tombstones and fetch walks
		dir_ops.push_back('{MODE_INSERT, 32'h0, 64'h1, 64'hab, 11'd0, 0, '0});
		dir_ops.push_back('{MODE_INSERT, 32'd1021, 64'h2, 64'hcd, 11'd0, 0, '0});
		dir_ops.push_back('{MODE_LOOKUP, '1, '1, 64'h0, 11'd0, 0, '0});
		dir_ops.push_back('{MODE_LOOKUP, 32'd1021, 64'h2, 64'h0, 11'd0, 0, '0});
		dir_ops.push_back('{MODE_REMOVE, 32'h0, 64'h0, 64'h0, 11'd0, 0, '0});
		dir_ops.push_back('{MODE_INSERT, 32'h0, 64'h1, 64'h77, 11'd0, 0, '0});
		dir_ops.push_back('{MODE_INSERT, 32'h0, 64'h9, 64'h99, 11'd0, 0, '0});
		dir_ops.push_back('{MODE_REMOVE, 32'h0, 64'h0, 64'h0, 11'd0, 0, '0});
		dir_ops.push_back('{MODE_FETCH, 32'h0, 64'h0, 64'h0, 11'd0, 0, '0});
		dir_ops.push_back('{MODE_FETCH, 32'h0, 64'h0, 64'h0, 11'd2, 0, '0});
		dir_ops.push_back('{MODE_FETCH, 32'h0, 64'h0, 64'h0, 11'd1020, 0, '0});
		dir_ops.push_back('{MODE_FETCH, '1, '1, '1, 11'd1024, 0, '0});
		dir_ops.push_back('{MODE_FETCH, 32'h0, 64'h0, 64'h0, 11'd1021, 0, '0});

		phase_buckets = '{11'd1021, 11'd7, 11'd1024, 11'd2047, 11'd0, 11'd1,
			11'd13, 11'd300, 11'd1021};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_ops[i]) send_op(dir_ops[i]);

		for (int ph = 0; ph < 9; ph++) begin
			if (ph > 0) write_buckets(phase_buckets[ph]);
			phase_items = (phase_buckets[ph] < 2) ? 60 : 160;
			for (int k = 0; k < phase_items; k++) begin
				if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
				send_op(random_op());
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN) @(posedge clk);
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
